[hw/rtl/indexed_min_heap_macros.svh]
// Assertion helpers for the indexed min-heap
`ifndef INDEXED_MIN_HEAP_MACROS_SVH
`define INDEXED_MIN_HEAP_MACROS_SVH

// same-cycle implication
`define IMH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IMH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/imh_pkg.sv]
package imh_pkg;

  localparam int unsigned SlotMaxW = 16;

  typedef enum logic [2:0] {
    FUNC_PUSH   = 3'd0,
    FUNC_UPDATE = 3'd1,
    FUNC_ERASE  = 3'd2,
    FUNC_PEEK   = 3'd3,
    FUNC_QUERY  = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_ABSENT = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [9:0]  handle;
    logic [63:0] key_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] top_key;
    logic [9:0]  top_handle;
    logic        top_valid;
    logic [10:0] entry_count;
    logic [9:0]  position;
    logic        present;
  } rsp_t;

  typedef struct packed {
    logic [63:0] key;
    logic [9:0]  handle;
  } heap_ent_t;

  typedef struct packed {
    logic                en;
    logic [SlotMaxW-1:0] addr;
    heap_ent_t           ent;
  } heap_wr_t;

endpackage

[hw/rtl/imh_req_if.sv]
interface imh_req_if;
  logic           valid;
  logic           ready;
  imh_pkg::req_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/imh_rsp_if.sv]
interface imh_rsp_if;
  logic           valid;
  logic           ready;
  imh_pkg::rsp_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/imh_heap_store.sv]
module imh_heap_store #(
  parameter int unsigned CAPACITY  = 1024,
  parameter int unsigned KEY_WIDTH = 64
) (
  input  logic                             clk_i,
  input  imh_pkg::heap_wr_t                wr_i,
  input  logic [$clog2(CAPACITY)-1:0]      rd_a_addr_i,
  input  logic [$clog2(CAPACITY)-1:0]      rd_b_addr_i,
  output imh_pkg::heap_ent_t               rd_a_o,
  output imh_pkg::heap_ent_t               rd_b_o,
  output imh_pkg::heap_ent_t               top_o
);

  localparam int unsigned SW = $clog2(CAPACITY);
  localparam int unsigned EW = KEY_WIDTH + 10;

  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_a_q, rd_b_q, top_q;
  logic [EW-1:0] wdata;
  logic [SW-1:0] waddr;

  assign wdata = {wr_i.ent.key[KEY_WIDTH-1:0], wr_i.ent.handle};
  assign waddr = SW'(wr_i.addr);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[waddr] <= wdata;
    end
    rd_a_q <= mem[rd_a_addr_i];
    rd_b_q <= mem[rd_b_addr_i];
  end

  // mirror of the root entry
  always_ff @(posedge clk_i) begin
    if (wr_i.en && waddr == '0) begin
      top_q <= wdata;
    end
  end

  assign rd_a_o.key    = 64'(rd_a_q[EW-1:10]);
  assign rd_a_o.handle = rd_a_q[9:0];
  assign rd_b_o.key    = 64'(rd_b_q[EW-1:10]);
  assign rd_b_o.handle = rd_b_q[9:0];
  assign top_o.key     = 64'(top_q[EW-1:10]);
  assign top_o.handle  = top_q[9:0];

endmodule

[hw/rtl/indexed_min_heap.sv]
// Indexed binary min-heap. One request at a time: it is taken, looked up in the
// handle position table and run to completion; the result then sits in an
// output register while the next request is taken. Peek, query, unused codes
// and requests that fail go from the lookup straight to the response. Push,
// update and erase may also move an entry up or down the heap, one level per
// step, and then write it to its final slot. A result still waiting in the
// output register holds the next one back. The heap memory has a single
// write port: one swap is written per cycle. After reset the position table
// is cleared entry by entry, and no request is taken until all HANDLE_COUNT
// entries are cleared.
`include "indexed_min_heap_macros.svh"

module indexed_min_heap #(
  parameter int unsigned CAPACITY     = 1024,
  parameter int unsigned HANDLE_COUNT = 1024,
  parameter int unsigned KEY_WIDTH    = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  imh_req_if.sink   req_i,
  imh_rsp_if.source rsp_o
);

  localparam int unsigned SW  = $clog2(CAPACITY);
  localparam int unsigned OW  = $clog2(CAPACITY + 1);
  localparam int unsigned HIW = $clog2(HANDLE_COUNT);
  localparam int unsigned CW  = SW + 2;
  localparam int unsigned KW  = KEY_WIDTH;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LOOK  = 4'd2;
  localparam logic [3:0] S_CKEY  = 4'd3;
  localparam logic [3:0] S_ELAST = 4'd4;
  localparam logic [3:0] S_RCMP  = 4'd5;
  localparam logic [3:0] S_SCMP  = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_RESP  = 4'd8;

  logic [3:0]     state_q, state_d;
  logic [2:0]     func_q, func_d;
  logic [9:0]     hdl_q, hdl_d;
  logic [KW-1:0]  key_q, key_d;
  logic           inr_q, inr_d;
  logic [OW-1:0]  occ_q, occ_d;
  logic [SW-1:0]  cur_q, cur_d;
  logic [KW-1:0]  mk_q, mk_d;
  logic [9:0]     mh_q, mh_d;
  logic           ers_q, ers_d;
  logic [1:0]     stat_q, stat_d;
  logic           pres_q, pres_d;
  logic [SW-1:0]  rpos_q, rpos_d;
  logic [HIW-1:0] clr_q, clr_d;
  logic           ov_q, ov_d, load;
  imh_pkg::rsp_t  od_q, od_d;

  // handle position table: {valid, slot}
  logic [SW:0]    pos_mem [HANDLE_COUNT];
  logic [SW:0]    prd_q;
  logic [HIW-1:0] pra, pwa;
  logic           pwe;
  logic [SW:0]    pwd;

  always_ff @(posedge clk_i) begin
    if (pwe) begin
      pos_mem[pwa] <= pwd;
    end
    prd_q <= pos_mem[pra];
  end

  imh_pkg::heap_wr_t  hwr;
  imh_pkg::heap_ent_t hrd_a, hrd_b, top;
  logic [SW-1:0]      ha, hb;

  imh_heap_store #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_store (
    .clk_i       (clk_i),
    .wr_i        (hwr),
    .rd_a_addr_i (ha),
    .rd_b_addr_i (hb),
    .rd_a_o      (hrd_a),
    .rd_b_o      (hrd_b),
    .top_o       (top)
  );

  logic          pv, pres_l;
  logic [SW-1:0] ps, par, par2, best;
  logic [OW-1:0] last;
  logic [CW-1:0] lc, rc;
  logic          lv, rv, l_lt, r_lt_m, r_lt_l, take_r, take_l;
  logic [KW-1:0] akey, bkey;

  assign pv     = prd_q[SW];
  assign ps     = prd_q[SW-1:0];
  assign pres_l = inr_q && pv && (OW'(ps) < occ_q);
  assign last   = occ_q - OW'(1);
  assign par    = SW'((cur_q - SW'(1)) >> 1);
  assign par2   = SW'((par - SW'(1)) >> 1);
  assign lc     = CW'({cur_q, 1'b1});
  assign rc     = lc + CW'(1);
  assign lv     = lc < CW'(occ_q);
  assign rv     = rc < CW'(occ_q);
  assign akey   = hrd_a.key[KW-1:0];
  assign bkey   = hrd_b.key[KW-1:0];
  assign l_lt   = lv && (akey < mk_q);
  assign r_lt_m = bkey < mk_q;
  assign r_lt_l = bkey < akey;
  assign take_r = rv && (l_lt ? r_lt_l : r_lt_m);
  assign take_l = l_lt && !take_r;
  assign best   = take_r ? SW'(rc) : SW'(lc);

  always_comb begin
    state_d = state_q;
    func_d  = func_q;
    hdl_d   = hdl_q;
    key_d   = key_q;
    inr_d   = inr_q;
    occ_d   = occ_q;
    cur_d   = cur_q;
    mk_d    = mk_q;
    mh_d    = mh_q;
    ers_d   = ers_q;
    stat_d  = stat_q;
    pres_d  = pres_q;
    rpos_d  = rpos_q;
    clr_d   = clr_q;
    load    = 1'b0;
    pra     = HIW'(req_i.data.handle);
    pwe     = 1'b0;
    pwa     = HIW'(mh_q);
    pwd     = {1'b1, cur_q};
    hwr     = '0;
    ha      = par;
    hb      = SW'(rc);
    req_i.ready = 1'b0;

    case (state_q)
      S_CLEAR: begin
        pwe   = 1'b1;
        pwa   = clr_q;
        pwd   = '0;
        clr_d = clr_q + HIW'(1);
        if (clr_q == HIW'(HANDLE_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          func_d  = req_i.data.func;
          hdl_d   = req_i.data.handle;
          key_d   = KW'(req_i.data.key_value);
          inr_d   = {22'd0, req_i.data.handle} < 32'(HANDLE_COUNT);
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        stat_d  = imh_pkg::STAT_OK;
        pres_d  = pres_l;
        rpos_d  = ps;
        cur_d   = ps;
        ers_d   = 1'b0;
        state_d = S_RESP;
        ha      = ps;
        case (func_q)
          imh_pkg::FUNC_PUSH: begin
            if (!inr_q) begin
              stat_d = imh_pkg::STAT_ABSENT;
            end else if (pres_l) begin
              state_d = S_CKEY;
            end else if (occ_q == OW'(CAPACITY)) begin
              stat_d = imh_pkg::STAT_FULL;
            end else begin
              occ_d  = occ_q + OW'(1);
              cur_d  = SW'(occ_q);
              mk_d   = key_q;
              mh_d   = hdl_q;
              pres_d = 1'b1;
              ha     = SW'((SW'(occ_q) - SW'(1)) >> 1);
              state_d = (occ_q == '0) ? S_FIN : S_RCMP;
            end
          end
          imh_pkg::FUNC_UPDATE: begin
            if (!pres_l) begin
              stat_d = imh_pkg::STAT_ABSENT;
            end else begin
              state_d = S_CKEY;
            end
          end
          imh_pkg::FUNC_ERASE: begin
            if (!pres_l) begin
              stat_d = imh_pkg::STAT_ABSENT;
            end else begin
              pwe    = 1'b1;
              pwa    = HIW'(hdl_q);
              pwd    = '0;
              pres_d = 1'b0;
              occ_d  = last;
              ha     = SW'(last);
              if (OW'(ps) != last) begin
                state_d = S_ELAST;
              end
            end
          end
          imh_pkg::FUNC_PEEK: begin
            if (occ_q == '0) begin
              stat_d = imh_pkg::STAT_EMPTY;
            end
          end
          imh_pkg::FUNC_QUERY: begin
            if (!pres_l) begin
              stat_d = imh_pkg::STAT_ABSENT;
            end
          end
          default: begin
          end
        endcase
      end
      S_CKEY: begin
        mk_d = key_q;
        mh_d = hrd_a.handle;
        ha   = SW'({cur_q, 1'b1});
        if (akey == key_q) begin
          state_d = S_RESP;
        end else if (key_q < akey) begin
          ha      = par;
          state_d = (cur_q == '0) ? S_FIN : S_RCMP;
        end else begin
          state_d = S_SCMP;
        end
      end
      S_ELAST: begin
        mk_d = akey;
        mh_d = hrd_a.handle;
        if (cur_q == '0) begin
          ha      = SW'({cur_q, 1'b1});
          state_d = S_SCMP;
        end else begin
          ha      = par;
          ers_d   = 1'b1;
          state_d = S_RCMP;
        end
      end
      S_RCMP: begin
        ers_d = 1'b0;
        if (mk_q < akey) begin
          hwr.en   = 1'b1;
          hwr.addr = imh_pkg::SlotMaxW'(cur_q);
          hwr.ent  = hrd_a;
          pwe      = 1'b1;
          pwa      = HIW'(hrd_a.handle);
          pwd      = {1'b1, cur_q};
          cur_d    = par;
          ha       = par2;
          state_d  = (par == '0) ? S_FIN : S_RCMP;
        end else if (ers_q) begin
          ha      = SW'({cur_q, 1'b1});
          state_d = S_SCMP;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SCMP: begin
        ha = SW'({best, 1'b1});
        hb = SW'({best, 1'b0} + (SW + 1)'(2));
        if (take_r || take_l) begin
          hwr.en   = 1'b1;
          hwr.addr = imh_pkg::SlotMaxW'(cur_q);
          hwr.ent  = take_r ? hrd_b : hrd_a;
          pwe      = 1'b1;
          pwa      = HIW'(take_r ? hrd_b.handle : hrd_a.handle);
          pwd      = {1'b1, cur_q};
          cur_d    = best;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        hwr.en         = 1'b1;
        hwr.addr       = imh_pkg::SlotMaxW'(cur_q);
        hwr.ent.key    = 64'(mk_q);
        hwr.ent.handle = mh_q;
        pwe            = 1'b1;
        rpos_d         = cur_q;
        state_d        = S_RESP;
      end
      S_RESP: begin
        if (!ov_q || rsp_o.ready) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    od_d.status      = stat_q;
    od_d.top_valid   = occ_q != '0;
    od_d.top_key     = (occ_q != '0) ? top.key : 64'd0;
    od_d.top_handle  = (occ_q != '0) ? top.handle : 10'd0;
    od_d.entry_count = 11'(occ_q);
    od_d.position    = pres_q ? 10'(rpos_q) : 10'd0;
    od_d.present     = pres_q;
    ov_d = load ? 1'b1 : (ov_q && !rsp_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      occ_q   <= '0;
      ov_q    <= 1'b0;
      ers_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      occ_q   <= occ_d;
      ov_q    <= ov_d;
      ers_q   <= ers_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    hdl_q  <= hdl_d;
    key_q  <= key_d;
    inr_q  <= inr_d;
    cur_q  <= cur_d;
    mk_q   <= mk_d;
    mh_q   <= mh_d;
    stat_q <= stat_d;
    pres_q <= pres_d;
    rpos_q <= rpos_d;
    if (load) begin
      od_q <= od_d;
    end
  end

  assign rsp_o.valid = ov_q;
  assign rsp_o.data  = od_q;

  `IMH_ASSERT_IMP(a_occ_bound, 1'b1, occ_q <= OW'(CAPACITY), "occupancy above capacity")
  `IMH_ASSERT_NXT(a_take_look, req_i.valid && req_i.ready, state_q == S_LOOK, "request not looked up")
  `IMH_ASSERT_IMP(a_clear_quiet, state_q == S_CLEAR, !hwr.en && !req_i.ready, "heap busy in clear")
  `IMH_ASSERT_IMP(a_top_valid, rsp_o.valid, rsp_o.data.top_valid == (rsp_o.data.entry_count != 11'd0), "top valid mismatch")

endmodule
